FILE: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertions on i_clk; the same-cycle one skips reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication
`define ASSERT_IMPLIES(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, also checked in reset
`define ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

FILE: sv/tsgd_pkg.sv
// ----------------------------------------------------------------------------
// tsgd_pkg
// Types, codes and zone tables of the touch swipe gesture detector.
// ----------------------------------------------------------------------------
package tsgd_pkg;

    localparam int COORD_W             = 12;
    localparam int SCOORD_W            = 14;
    localparam int BANK_SLOTS          = 4;
    localparam int STATIC_BANK_DEFAULT = 2;
    localparam int DYN_ENABLE_BIT      = 4;
    localparam int QUEUE_DEPTH         = 2;
    localparam int CFG_IDX_W           = 2;
    localparam int CFG_DATA_W          = 12;

    // Input actions
    localparam logic [2:0] ACT_POS_X = 3'd0;
    localparam logic [2:0] ACT_POS_Y = 3'd1;
    localparam logic [2:0] ACT_SLOT  = 3'd2;
    localparam logic [2:0] ACT_LIFT  = 3'd3;

    // Result sources
    localparam logic [1:0] SRC_NONE    = 2'd0;
    localparam logic [1:0] SRC_STATIC  = 2'd1;
    localparam logic [1:0] SRC_DYNAMIC = 2'd2;

    // Commands from front to back
    localparam logic [1:0] OP_NOP   = 2'd0;
    localparam logic [1:0] OP_CLEAR = 2'd1;
    localparam logic [1:0] OP_EVAL  = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_GESTURE_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BUTTON_LIMIT_Y = 2'd1;

    localparam logic [7:0]         ENABLE_RESET       = 8'd0;
    localparam logic [COORD_W-1:0] BUTTON_LIMIT_RESET = 12'd1900;

    typedef struct packed {
        logic [2:0]         action;
        logic [COORD_W-1:0] value;
        logic               screen_off;
    } t_in_item;

    typedef struct packed {
        logic       trigger;
        logic [1:0] source;
    } t_result;

    typedef struct packed {
        logic [1:0]         op;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
    } t_cmd;

    typedef struct packed {
        logic signed [SCOORD_W-1:0] xmin;
        logic signed [SCOORD_W-1:0] xmax;
        logic signed [SCOORD_W-1:0] ymin;
        logic signed [SCOORD_W-1:0] ymax;
    } t_zone;

    localparam t_zone ZONE_EMPTY = '{14'sd0, 14'sd0, 14'sd0, 14'sd0};

    // Static zones, [stage][bank]; banks past the defined ones never hit
    localparam t_zone STATIC_ZONES [0:2][0:BANK_SLOTS-1] = '{
        '{'{14'sd700, 14'sd1280, 14'sd1900, 14'sd2400},
          '{14'sd0,   14'sd300,  14'sd1900, 14'sd2400}, ZONE_EMPTY, ZONE_EMPTY},
        '{'{14'sd350, 14'sd650,  14'sd1900, 14'sd2400},
          '{14'sd350, 14'sd650,  14'sd1900, 14'sd2400}, ZONE_EMPTY, ZONE_EMPTY},
        '{'{14'sd0,   14'sd300,  14'sd1900, 14'sd2400},
          '{14'sd700, 14'sd1280, 14'sd1900, 14'sd2400}, ZONE_EMPTY, ZONE_EMPTY}
    };

    // Dynamic bank: fixed first zone, later targets relative to the hit point
    localparam t_zone DYN_ZONE_ONE = '{14'sd800, 14'sd1280, 14'sd800, 14'sd1600};
    localparam logic signed [SCOORD_W-1:0] DYN2_X_OFF  = -14'sd300;
    localparam logic signed [SCOORD_W-1:0] DYN2_X_SIZE = 14'sd200;
    localparam logic signed [SCOORD_W-1:0] DYN2_Y_OFF  = 14'sd100;
    localparam logic signed [SCOORD_W-1:0] DYN2_Y_SIZE = 14'sd200;
    localparam logic signed [SCOORD_W-1:0] DYN3_X_OFF  = -14'sd300;
    localparam logic signed [SCOORD_W-1:0] DYN3_X_SIZE = 14'sd200;
    localparam logic signed [SCOORD_W-1:0] DYN3_Y_OFF  = 14'sd100;
    localparam logic signed [SCOORD_W-1:0] DYN3_Y_SIZE = 14'sd200;

    // Strict point-in-rectangle test
    function automatic logic in_zone(input logic signed [SCOORD_W-1:0] x,
                                     input logic signed [SCOORD_W-1:0] y,
                                     input t_zone z);
        in_zone = (x < z.xmax) && (x > z.xmin) && (y < z.ymax) && (y > z.ymin);
    endfunction

    // Widen a coordinate to the signed compare width
    function automatic logic signed [SCOORD_W-1:0] to_signed(
            input logic [COORD_W-1:0] v);
        to_signed = $signed({{(SCOORD_W-COORD_W){1'b0}}, v});
    endfunction

endpackage

FILE: sv/tsgd_fifo.sv
// ----------------------------------------------------------------------------
// tsgd_fifo
// Small register queue with fall-through read of the oldest entry.
// ----------------------------------------------------------------------------
module tsgd_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tsgd_pkg::QUEUE_DEPTH
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [0:DEPTH-1];
    logic [AW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [AW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CW-1:0]    r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    // Advance pointers with wrap and track fill level
    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == AW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == AW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (do_pop && !do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    // Store pushed item
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: sv/tsgd_front.sv
// ----------------------------------------------------------------------------
// tsgd_front
// Latches touch coordinates and turns each event into one back-end command.
// ----------------------------------------------------------------------------
module tsgd_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  tsgd_pkg::t_in_item            i_item,
    input  logic [7:0]                    i_gesture_enable,
    input  logic [tsgd_pkg::COORD_W-1:0]  i_button_limit_y,
    output tsgd_pkg::t_cmd                o_cmd
);

    logic [tsgd_pkg::COORD_W-1:0] r_last_x, n_last_x;
    logic [tsgd_pkg::COORD_W-1:0] r_last_y, n_last_y;
    logic                         r_x_seen, n_x_seen;
    logic                         r_y_seen, n_y_seen;

    // Classify the event and update the coordinate latch
    always_comb begin
        n_last_x = r_last_x;
        n_last_y = r_last_y;
        n_x_seen = r_x_seen;
        n_y_seen = r_y_seen;
        o_cmd.op = tsgd_pkg::OP_NOP;
        o_cmd.x  = r_last_x;
        o_cmd.y  = r_last_y;
        if (i_gesture_enable != '0) begin
            case (i_item.action)
                tsgd_pkg::ACT_SLOT: begin
                    o_cmd.op = tsgd_pkg::OP_CLEAR;
                end
                tsgd_pkg::ACT_LIFT: begin
                    if (r_last_y < i_button_limit_y) begin
                        o_cmd.op = tsgd_pkg::OP_CLEAR;
                    end
                end
                default: begin
                    if (i_item.action == tsgd_pkg::ACT_POS_X) begin
                        n_last_x = i_item.value;
                        n_x_seen = 1'b1;
                    end else if (i_item.action == tsgd_pkg::ACT_POS_Y) begin
                        n_last_y = i_item.value;
                        n_y_seen = 1'b1;
                    end
                    // Consume the point once both coordinates are in
                    if (n_x_seen && n_y_seen) begin
                        n_x_seen = 1'b0;
                        n_y_seen = 1'b0;
                        o_cmd.x  = n_last_x;
                        o_cmd.y  = n_last_y;
                        if (!i_item.screen_off) begin
                            o_cmd.op = tsgd_pkg::OP_EVAL;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_x <= '0;
            r_last_y <= '0;
            r_x_seen <= 1'b0;
            r_y_seen <= 1'b0;
        end else if (i_accept) begin
            r_last_x <= n_last_x;
            r_last_y <= n_last_y;
            r_x_seen <= n_x_seen;
            r_y_seen <= n_y_seen;
        end
    end

endmodule

FILE: sv/tsgd_back.sv
// ----------------------------------------------------------------------------
// tsgd_back
// Runs commands against the zone banks and produces one result per command.
// ----------------------------------------------------------------------------
module tsgd_back #(
    parameter int STATIC_BANK_COUNT = tsgd_pkg::STATIC_BANK_DEFAULT
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cmd_valid,
    input  tsgd_pkg::t_cmd     i_cmd,
    output logic               o_cmd_pop,
    input  logic               i_res_full,
    output logic               o_res_push,
    output tsgd_pkg::t_result  o_result,
    input  logic [7:0]         i_gesture_enable
);

    logic [STATIC_BANK_COUNT-1:0] r_s1, n_s1;
    logic [STATIC_BANK_COUNT-1:0] r_s2, n_s2;
    logic                         r_d1, n_d1;
    logic                         r_d2, n_d2;
    tsgd_pkg::t_zone              r_tgt, n_tgt;

    logic signed [tsgd_pkg::SCOORD_W-1:0] px, py;
    logic [STATIC_BANK_COUNT-1:0] hit1, hit2, hit3;
    logic                         dyn_hit1;

    assign o_cmd_pop  = i_cmd_valid && !i_res_full;
    assign o_res_push = o_cmd_pop;
    assign px = tsgd_pkg::to_signed(i_cmd.x);
    assign py = tsgd_pkg::to_signed(i_cmd.y);

    // Fixed zone compares for every bank
    always_comb begin
        for (int i = 0; i < STATIC_BANK_COUNT; i++) begin
            hit1[i] = tsgd_pkg::in_zone(px, py, tsgd_pkg::STATIC_ZONES[0][i]);
            hit2[i] = tsgd_pkg::in_zone(px, py, tsgd_pkg::STATIC_ZONES[1][i]);
            hit3[i] = tsgd_pkg::in_zone(px, py, tsgd_pkg::STATIC_ZONES[2][i]);
        end
        dyn_hit1 = tsgd_pkg::in_zone(px, py, tsgd_pkg::DYN_ZONE_ONE);
    end

    // Walk the banks in order; a completion clears all progress
    always_comb begin
        n_s1 = r_s1;
        n_s2 = r_s2;
        n_d1 = r_d1;
        n_d2 = r_d2;
        n_tgt = r_tgt;
        o_result.trigger = 1'b0;
        o_result.source  = tsgd_pkg::SRC_NONE;
        case (i_cmd.op)
            tsgd_pkg::OP_CLEAR: begin
                n_s1 = '0;
                n_s2 = '0;
                n_d1 = 1'b0;
                n_d2 = 1'b0;
            end
            tsgd_pkg::OP_EVAL: begin
                for (int i = 0; i < STATIC_BANK_COUNT; i++) begin
                    if (i_gesture_enable[i] && (n_s1[i] || hit1[i])) begin
                        n_s1[i] = 1'b1;
                        if (n_s2[i] || hit2[i]) begin
                            n_s2[i] = 1'b1;
                            if (hit3[i]) begin
                                if (o_result.source == tsgd_pkg::SRC_NONE) begin
                                    o_result.source = tsgd_pkg::SRC_STATIC;
                                end
                                n_s1 = '0;
                                n_s2 = '0;
                                n_d1 = 1'b0;
                                n_d2 = 1'b0;
                            end
                        end
                    end
                end
                if (i_gesture_enable[tsgd_pkg::DYN_ENABLE_BIT] && (n_d1 || dyn_hit1)) begin
                    if (!n_d1) begin
                        // Place the second target; the same point cannot hit it
                        n_d1 = 1'b1;
                        n_tgt.xmin = px + tsgd_pkg::DYN2_X_OFF;
                        n_tgt.xmax = px + tsgd_pkg::DYN2_X_OFF + tsgd_pkg::DYN2_X_SIZE;
                        n_tgt.ymin = py + tsgd_pkg::DYN2_Y_OFF;
                        n_tgt.ymax = py + tsgd_pkg::DYN2_Y_OFF + tsgd_pkg::DYN2_Y_SIZE;
                    end else if (n_d2) begin
                        if (tsgd_pkg::in_zone(px, py, n_tgt)) begin
                            if (o_result.source == tsgd_pkg::SRC_NONE) begin
                                o_result.source = tsgd_pkg::SRC_DYNAMIC;
                            end
                            n_s1 = '0;
                            n_s2 = '0;
                            n_d1 = 1'b0;
                            n_d2 = 1'b0;
                        end
                    end else if (tsgd_pkg::in_zone(px, py, n_tgt)) begin
                        // Second target hit: place the third one
                        n_d2 = 1'b1;
                        n_tgt.xmin = px + tsgd_pkg::DYN3_X_OFF;
                        n_tgt.xmax = px + tsgd_pkg::DYN3_X_OFF + tsgd_pkg::DYN3_X_SIZE;
                        n_tgt.ymin = py + tsgd_pkg::DYN3_Y_OFF;
                        n_tgt.ymax = py + tsgd_pkg::DYN3_Y_OFF + tsgd_pkg::DYN3_Y_SIZE;
                    end
                end
                o_result.trigger = (o_result.source != tsgd_pkg::SRC_NONE);
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1  <= '0;
            r_s2  <= '0;
            r_d1  <= 1'b0;
            r_d2  <= 1'b0;
            r_tgt <= '0;
        end else if (o_cmd_pop) begin
            r_s1  <= n_s1;
            r_s2  <= n_s2;
            r_d1  <= n_d1;
            r_d2  <= n_d2;
            r_tgt <= n_tgt;
        end
    end

endmodule

FILE: sv/touch_swipe_gesture_detector.sv
// ----------------------------------------------------------------------------
// touch_swipe_gesture_detector
// Swipe gesture detector on a touch event stream, requesting a power key press.
// ----------------------------------------------------------------------------
// Every accepted touch event yields exactly one result item, in order. An
// event is taken in any cycle where full is low, one per cycle while results
// are popped: the front latches coordinates and queues a command in the
// cycle it is accepted, the back evaluates all zone banks for one command
// per cycle while the result queue has room, and each item is registered in
// the command queue, then the result queue. Two-entry queues sit between
// front and back and on the result side, so a stalled consumer fills them
// before full rises. Configuration writes are always ready and take effect
// at once; write them only while no events are in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module touch_swipe_gesture_detector #(
    parameter int STATIC_BANK_COUNT = tsgd_pkg::STATIC_BANK_DEFAULT,
    parameter int QUEUE_DEPTH       = tsgd_pkg::QUEUE_DEPTH
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    output logic                             full,
    input  tsgd_pkg::t_in_item               i_item,
    output logic                             empty,
    input  logic                             pop,
    output tsgd_pkg::t_result                o_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [tsgd_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [tsgd_pkg::CFG_DATA_W-1:0]  i_cfg_data
);

    localparam int CMD_W = $bits(tsgd_pkg::t_cmd);
    localparam int RES_W = $bits(tsgd_pkg::t_result);

    logic [7:0]                   r_gesture_enable;
    logic [tsgd_pkg::COORD_W-1:0] r_button_limit_y;
    logic                         in_accept;
    tsgd_pkg::t_cmd               front_cmd, back_cmd;
    logic                         cmd_empty, cmd_pop;
    logic                         res_full, res_push;
    tsgd_pkg::t_result            back_result;

    assign o_cfg_ready = 1'b1;
    assign in_accept   = push && !full;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gesture_enable <= tsgd_pkg::ENABLE_RESET;
            r_button_limit_y <= tsgd_pkg::BUTTON_LIMIT_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                tsgd_pkg::REG_GESTURE_ENABLE: r_gesture_enable <= i_cfg_data[7:0];
                tsgd_pkg::REG_BUTTON_LIMIT_Y: r_button_limit_y <= i_cfg_data;
                default: begin
                end
            endcase
        end
    end

    tsgd_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_accept         (in_accept),
        .i_item           (i_item),
        .i_gesture_enable (r_gesture_enable),
        .i_button_limit_y (r_button_limit_y),
        .o_cmd            (front_cmd)
    );

    tsgd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_cmd_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_data  (front_cmd),
        .i_pop   (cmd_pop),
        .o_data  (back_cmd),
        .o_full  (full),
        .o_empty (cmd_empty)
    );

    tsgd_back #(
        .STATIC_BANK_COUNT (STATIC_BANK_COUNT)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cmd_valid      (!cmd_empty),
        .i_cmd            (back_cmd),
        .o_cmd_pop        (cmd_pop),
        .i_res_full       (res_full),
        .o_res_push       (res_push),
        .o_result         (back_result),
        .i_gesture_enable (r_gesture_enable)
    );

    tsgd_fifo #(
        .WIDTH (RES_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_res_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (back_result),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_full  (res_full),
        .o_empty (empty)
    );

    // A shown result names a source exactly when it triggers
    `ASSERT_IMPLIES(a_trigger_source, !empty, o_result.trigger == (o_result.source != tsgd_pkg::SRC_NONE))
    // With gestures off, events produce no work for the back end
    `ASSERT_IMPLIES(a_disabled_nop, in_accept && (r_gesture_enable == '0), front_cmd.op == tsgd_pkg::OP_NOP)
    // Reset leaves no result waiting
    `ASSERT_NEXT(a_reset_empty, !i_rst_n, empty && !full)

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// touch_swipe_gesture_detector testbench
// Drives touch events and configuration writes into the detector, predicts the
// power-key request for every accepted event and checks each result item in
// order. A short directed table comes first, then phases of random swipes,
// broken swipes and noise under several gesture settings, with random idling
// on both the event and the result side.
// ----------------------------------------------------------------------------
module testbench;

    localparam int CLK_PERIOD    = 4;
    localparam int RESET_CYCLES  = 11;
    localparam int MAX_GAP       = 12;
    localparam int ITEM_GOAL     = 800;
    localparam int ACTIVE_PHASES = 7;
    localparam int STALL_LIMIT   = 2000;
    localparam int DRAIN_CYCLES  = 8;

    // Actions the block ignores
    localparam logic [2:0] ACT_OTHER_MIN = 3'd4;
    localparam logic [2:0] ACT_OTHER_MAX = 3'd7;

    // Static zones: one row of three columns, strict bounds
    localparam int ROW_Y_MIN    = 1900;
    localparam int ROW_Y_MAX    = 2400;
    localparam int COL_WIDE_MIN = 700;
    localparam int COL_WIDE_MAX = 1280;
    localparam int COL_MID_MIN  = 350;
    localparam int COL_MID_MAX  = 650;
    localparam int COL_EDGE_MIN = 0;
    localparam int COL_EDGE_MAX = 300;

    // Dynamic bank: fixed first zone, then targets relative to the last hit
    localparam int DYN_X_MIN  = 800;
    localparam int DYN_X_MAX  = 1280;
    localparam int DYN_Y_MIN  = 800;
    localparam int DYN_Y_MAX  = 1600;
    localparam int TGT_X_OFF  = -300;
    localparam int TGT_X_SIZE = 200;
    localparam int TGT_Y_OFF  = 100;
    localparam int TGT_Y_SIZE = 200;

    localparam tsgd_pkg::t_result NO_GESTURE = '{1'b0, tsgd_pkg::SRC_NONE};

    typedef enum bit {ROW_EVENT, ROW_CONFIG} t_row_kind;

    typedef struct {
        t_row_kind          kind;
        logic [7:0]         enable;
        logic [11:0]        limit;
        tsgd_pkg::t_in_item ev;
        bit                 typed;
        tsgd_pkg::t_result  want;
    } t_stim_row;

    logic                            i_clk       = 1'b0;
    logic                            i_rst_n     = 1'b0;
    logic                            push        = 1'b0;
    logic                            full;
    tsgd_pkg::t_in_item              i_item      = '0;
    logic                            empty;
    logic                            pop         = 1'b0;
    tsgd_pkg::t_result               o_result;
    logic                            i_cfg_valid = 1'b0;
    logic                            o_cfg_ready;
    logic [tsgd_pkg::CFG_IDX_W-1:0]  i_cfg_index = tsgd_pkg::REG_GESTURE_ENABLE;
    logic [tsgd_pkg::CFG_DATA_W-1:0] i_cfg_data  = '0;

    // Predicted detector state
    logic [7:0]          gst_enable = 8'd0;
    logic [11:0]         gst_limit  = 12'd1900;
    logic [11:0]         gst_last_x = '0;
    logic [11:0]         gst_last_y = '0;
    bit                  gst_x_seen;
    bit                  gst_y_seen;
    bit                  gst_stage_one [tsgd_pkg::BANK_SLOTS];
    bit                  gst_stage_two [tsgd_pkg::BANK_SLOTS];
    bit                  gst_dyn_one;
    bit                  gst_dyn_two;
    logic signed [13:0]  gst_tgt_xmin = '0;
    logic signed [13:0]  gst_tgt_xmax = '0;
    logic signed [13:0]  gst_tgt_ymin = '0;
    logic signed [13:0]  gst_tgt_ymax = '0;

    tsgd_pkg::t_result pending_results [$];
    int      mismatch_count = 0;
    int      live_items     = 0;
    int      stall_cycles   = 0;
    int      calm_left [2];

    touch_swipe_gesture_detector u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .full        (full),
        .i_item      (i_item),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Gesture predictor
    // ------------------------------------------------------------------------
    function automatic bit in_box(input int x, input int y, input int x0, input int x1,
                                  input int y0, input int y1);
        return x > x0 && x < x1 && y > y0 && y < y1;
    endfunction

    function automatic int col_min(input int col);
        case (col)
            0:       return COL_WIDE_MIN;
            1:       return COL_MID_MIN;
            default: return COL_EDGE_MIN;
        endcase
    endfunction

    function automatic int col_max(input int col);
        case (col)
            0:       return COL_WIDE_MAX;
            1:       return COL_MID_MAX;
            default: return COL_EDGE_MAX;
        endcase
    endfunction

    // Bank 0 sweeps wide to edge column, bank 1 the other way
    function automatic bit static_hit(input int stage, input int bank, input int x, input int y);
        int col;
        col = (bank == 0) ? stage : 2 - stage;
        return in_box(x, y, col_min(col), col_max(col), ROW_Y_MIN, ROW_Y_MAX);
    endfunction

    function automatic void drop_progress();
        for (int b = 0; b < tsgd_pkg::BANK_SLOTS; b++) begin
            gst_stage_one[b] = 1'b0;
            gst_stage_two[b] = 1'b0;
        end
        gst_dyn_one = 1'b0;
        gst_dyn_two = 1'b0;
    endfunction

    function automatic void place_target(input int x, input int y);
        gst_tgt_xmin = 14'(x + TGT_X_OFF);
        gst_tgt_xmax = 14'(x + TGT_X_OFF + TGT_X_SIZE);
        gst_tgt_ymin = 14'(y + TGT_Y_OFF);
        gst_tgt_ymax = 14'(y + TGT_Y_OFF + TGT_Y_SIZE);
    endfunction

    function automatic bit in_target(input int x, input int y);
        return in_box(x, y, gst_tgt_xmin, gst_tgt_xmax, gst_tgt_ymin, gst_tgt_ymax);
    endfunction

    // Run one latched point through every enabled bank; first completion names the source
    function automatic logic [1:0] evaluate_point(input int x, input int y);
        logic [1:0] src;
        src = tsgd_pkg::SRC_NONE;
        for (int b = 0; b < tsgd_pkg::STATIC_BANK_DEFAULT; b++) begin
            if (gst_enable[b] && (gst_stage_one[b] || static_hit(0, b, x, y))) begin
                gst_stage_one[b] = 1'b1;
                if (gst_stage_two[b] || static_hit(1, b, x, y)) begin
                    gst_stage_two[b] = 1'b1;
                    if (static_hit(2, b, x, y)) begin
                        if (src == tsgd_pkg::SRC_NONE)
                            src = tsgd_pkg::SRC_STATIC;
                        drop_progress();
                    end
                end
            end
        end
        if (gst_enable[tsgd_pkg::DYN_ENABLE_BIT] &&
            (gst_dyn_one || in_box(x, y, DYN_X_MIN, DYN_X_MAX, DYN_Y_MIN, DYN_Y_MAX))) begin
            if (!gst_dyn_one) begin
                gst_dyn_one = 1'b1;
                place_target(x, y);
            end
            if (gst_dyn_two || in_target(x, y)) begin
                if (!gst_dyn_two) begin
                    gst_dyn_two = 1'b1;
                    place_target(x, y);
                end
                if (in_target(x, y)) begin
                    if (src == tsgd_pkg::SRC_NONE)
                        src = tsgd_pkg::SRC_DYNAMIC;
                    drop_progress();
                end
            end
        end
        return src;
    endfunction

    function automatic tsgd_pkg::t_result predict_gesture(input tsgd_pkg::t_in_item ev);
        tsgd_pkg::t_result res;
        res = NO_GESTURE;
        if (gst_enable == 8'd0)
            return res;
        if (ev.action == tsgd_pkg::ACT_SLOT) begin
            drop_progress();
            return res;
        end
        if (ev.action == tsgd_pkg::ACT_LIFT) begin
            if (gst_last_y < gst_limit)
                drop_progress();
            return res;
        end
        if (ev.action == tsgd_pkg::ACT_POS_X) begin
            gst_last_x = ev.value;
            gst_x_seen = 1'b1;
        end else if (ev.action == tsgd_pkg::ACT_POS_Y) begin
            gst_last_y = ev.value;
            gst_y_seen = 1'b1;
        end
        if (gst_x_seen && gst_y_seen) begin
            gst_x_seen = 1'b0;
            gst_y_seen = 1'b0;
            if (!ev.screen_off)
                res.source = evaluate_point(gst_last_x, gst_last_y);
        end
        res.trigger = (res.source != tsgd_pkg::SRC_NONE);
        return res;
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic tsgd_pkg::t_in_item make_item(input logic [2:0] action, input int value,
                                                     input bit scr);
        tsgd_pkg::t_in_item it;
        it.action     = action;
        it.value      = value[11:0];
        it.screen_off = scr;
        return it;
    endfunction

    function automatic t_stim_row cfg_row(input logic [7:0] enable, input logic [11:0] limit);
        t_stim_row r;
        r.kind   = ROW_CONFIG;
        r.enable = enable;
        r.limit  = limit;
        r.ev     = '0;
        r.typed  = 1'b0;
        r.want   = NO_GESTURE;
        return r;
    endfunction

    function automatic t_stim_row ev_row(input logic [2:0] action, input int value,
                                         input bit scr);
        t_stim_row r;
        r.kind   = ROW_EVENT;
        r.enable = '0;
        r.limit  = '0;
        r.ev     = make_item(action, value, scr);
        r.typed  = 1'b0;
        r.want   = NO_GESTURE;
        return r;
    endfunction

    // Event whose result is plainly no gesture
    function automatic t_stim_row quiet_row(input logic [2:0] action, input int value,
                                            input bit scr);
        t_stim_row r;
        r       = ev_row(action, value, scr);
        r.typed = 1'b1;
        return r;
    endfunction

    // Idle cycles per item, with occasional stretches of none
    function automatic int draw_gap(input int side);
        if (calm_left[side] > 0) begin
            calm_left[side]--;
            return 0;
        end
        if ($urandom_range(0, 15) == 0) begin
            calm_left[side] = $urandom_range(8, 40);
            return 0;
        end
        return $urandom_range(0, MAX_GAP);
    endfunction

    // Random value in [lo, hi], landing on either bound now and then
    function automatic int span(input int lo, input int hi);
        case ($urandom_range(0, 9))
            0:       return lo;
            1:       return hi;
            default: return $urandom_range(lo + 1, hi - 1);
        endcase
    endfunction

    task automatic send_event(input tsgd_pkg::t_in_item ev, input bit typed,
                              input tsgd_pkg::t_result want);
        int                gap;
        tsgd_pkg::t_result guess;
        gap = draw_gap(0);
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_item <= ev;
        push   <= 1'b1;
        do @(posedge i_clk); while (full);
        if (gst_enable != 8'd0)
            live_items++;
        guess = predict_gesture(ev);
        pending_results.push_back(typed ? want : guess);
    endtask

    task automatic send_noise();
        send_event(make_item(3'($urandom_range(0, 7)), $urandom_range(0, 4095),
                             1'($urandom_range(0, 1))), 1'b0, NO_GESTURE);
    endtask

    // Send X and Y in either order; sometimes only one coordinate goes out
    task automatic send_point(input int x, input int y);
        bit scr;
        bit y_first;
        bit lone;
        scr     = ($urandom_range(0, 15) == 0);
        y_first = 1'($urandom_range(0, 1));
        lone    = ($urandom_range(0, 19) == 0);
        if (y_first) begin
            send_event(make_item(tsgd_pkg::ACT_POS_Y, y, scr), 1'b0, NO_GESTURE);
            if (!lone)
                send_event(make_item(tsgd_pkg::ACT_POS_X, x, scr), 1'b0, NO_GESTURE);
        end else begin
            send_event(make_item(tsgd_pkg::ACT_POS_X, x, scr), 1'b0, NO_GESTURE);
            if (!lone)
                send_event(make_item(tsgd_pkg::ACT_POS_Y, y, scr), 1'b0, NO_GESTURE);
        end
    endtask

    task automatic random_sequence();
        int kind;
        int bank;
        int col;
        int px;
        int py;
        int x_reach;
        int y_skip;
        kind = $urandom_range(0, 11);
        if (kind <= 5) begin
            // static swipe through the three columns of one bank
            bank = kind / 3;
            for (int st = 0; st < 3; st++) begin
                col = (bank == 0) ? st : 2 - st;
                repeat ($urandom_range(1, 2))
                    send_point(span(col_min(col), col_max(col)), span(ROW_Y_MIN, ROW_Y_MAX));
                if ($urandom_range(0, 11) == 0)
                    send_noise();
            end
        end else if (kind <= 9) begin
            // dynamic chain; the last kind first arms bank 0 and aims the chain
            // at its final column so that both banks may complete on one point
            x_reach = TGT_X_SIZE;
            y_skip  = 0;
            if (kind == 9) begin
                for (int st = 0; st < 2; st++)
                    send_point(span(col_min(st), col_max(st)), span(ROW_Y_MIN, ROW_Y_MAX));
                px      = span(DYN_X_MIN, DYN_X_MIN + 40);
                py      = span(DYN_Y_MAX - 40, DYN_Y_MAX);
                x_reach = 50;
                y_skip  = 150;
            end else begin
                px = span(DYN_X_MIN, DYN_X_MAX);
                py = span(DYN_Y_MIN, DYN_Y_MAX);
            end
            send_point(px, py);
            repeat (2) begin
                if ($urandom_range(0, 11) == 0)
                    send_noise();
                px = span(px + TGT_X_OFF, px + TGT_X_OFF + x_reach);
                py = span(py + TGT_Y_OFF + y_skip, py + TGT_Y_OFF + TGT_Y_SIZE);
                send_point(px, py);
            end
        end else if (kind == 10) begin
            send_event(make_item($urandom_range(0, 1) ? tsgd_pkg::ACT_SLOT : tsgd_pkg::ACT_LIFT,
                                 $urandom_range(0, 4095), 1'($urandom_range(0, 1))),
                       1'b0, NO_GESTURE);
        end else begin
            repeat ($urandom_range(1, 4)) send_noise();
        end
    endtask

    // Wait until every predicted result has been popped
    task automatic settle_block();
        if (push)
            push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_config(input logic [7:0] enable, input logic [11:0] limit);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= tsgd_pkg::REG_GESTURE_ENABLE;
        i_cfg_data  <= tsgd_pkg::CFG_DATA_W'(enable);
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_index <= tsgd_pkg::REG_BUTTON_LIMIT_Y;
        i_cfg_data  <= limit;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        gst_enable = enable;
        gst_limit  = limit;
    endtask

    // ------------------------------------------------------------------------
    // Main sequence: directed table, then random phases
    // ------------------------------------------------------------------------
    initial begin : stimulus
        t_stim_row   rows [$];
        int          phase_start;
        logic [7:0]  enable;
        logic [11:0] limit;

        rows = {
            // disabled after reset
            quiet_row(tsgd_pkg::ACT_POS_X, 4095, 1'b0),
            quiet_row(tsgd_pkg::ACT_POS_Y, 0, 1'b1),
            cfg_row(8'h13, 12'd1900),
            // bank 0 sweep, with an ignored action in between
            ev_row(tsgd_pkg::ACT_POS_X, 1000, 1'b0),
            ev_row(tsgd_pkg::ACT_POS_Y, 2000, 1'b0),
            quiet_row(ACT_OTHER_MAX, 4095, 1'b1),
            ev_row(tsgd_pkg::ACT_POS_X, 500, 1'b0),
            ev_row(tsgd_pkg::ACT_POS_Y, 2000, 1'b0),
            ev_row(tsgd_pkg::ACT_POS_Y, 2000, 1'b0),
            ev_row(tsgd_pkg::ACT_POS_X, 100, 1'b0),
            quiet_row(tsgd_pkg::ACT_SLOT, 0, 1'b0),
            // dynamic start, then a lift below the button row clears it
            ev_row(tsgd_pkg::ACT_POS_X, 1000, 1'b0),
            ev_row(tsgd_pkg::ACT_POS_Y, 1000, 1'b0),
            quiet_row(tsgd_pkg::ACT_LIFT, 4095, 1'b0),
            ev_row(tsgd_pkg::ACT_POS_X, 1000, 1'b0),
            ev_row(tsgd_pkg::ACT_POS_Y, 1000, 1'b0),
            ev_row(tsgd_pkg::ACT_POS_X, 800, 1'b0),
            ev_row(tsgd_pkg::ACT_POS_Y, 1200, 1'b0),
            // screen off consumes the point without detection
            quiet_row(tsgd_pkg::ACT_POS_X, 600, 1'b1),
            quiet_row(tsgd_pkg::ACT_POS_Y, 1400, 1'b1),
            ev_row(tsgd_pkg::ACT_POS_X, 600, 1'b0),
            ev_row(tsgd_pkg::ACT_POS_Y, 1400, 1'b0),
            cfg_row(8'hFF, 12'd0),
            // point on a zone edge, lift that never clears, ignored action
            ev_row(tsgd_pkg::ACT_POS_X, 700, 1'b0),
            ev_row(tsgd_pkg::ACT_POS_Y, 2000, 1'b0),
            quiet_row(tsgd_pkg::ACT_LIFT, 0, 1'b0),
            quiet_row(ACT_OTHER_MIN, 0, 1'b0)
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (rows[i]) begin
            if (rows[i].kind == ROW_CONFIG) begin
                settle_block();
                write_config(rows[i].enable, rows[i].limit);
            end else begin
                send_event(rows[i].ev, rows[i].typed, rows[i].want);
            end
        end

        for (int p = 0; p <= ACTIVE_PHASES; p++) begin
            case (p)
                0:       begin enable = 8'hFF; limit = 12'd4095; end
                1:       begin enable = 8'h01; limit = 12'd0; end
                2:       begin enable = 8'h02; limit = 12'd1900; end
                3:       begin enable = 8'h10; limit = 12'($urandom_range(0, 4095)); end
                4:       begin enable = 8'h00; limit = 12'd1900; end
                5:       begin
                    enable = 8'($urandom_range(1, 255));
                    limit  = 12'($urandom_range(0, 4095));
                end
                6:       begin enable = 8'h13; limit = 12'($urandom_range(0, 4095)); end
                default: begin enable = 8'h91; limit = 12'd2100; end
            endcase
            settle_block();
            write_config(enable, limit);
            if (enable == 8'd0) begin
                repeat (40) send_noise();
            end else begin
                phase_start = live_items;
                while (live_items - phase_start < ITEM_GOAL / ACTIVE_PHASES)
                    random_sequence();
            end
        end

        settle_block();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("touch_swipe_gesture_detector test passed");
        else
            $display("touch_swipe_gesture_detector test failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Result side: pop with random stalls, check against the oldest prediction
    // ------------------------------------------------------------------------
    initial begin : result_sink
        tsgd_pkg::t_result want;
        int                gap;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            gap = draw_gap(1);
            if (gap > 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            do @(posedge i_clk); while (empty);
            if (pending_results.size() == 0) begin
                mismatch_count++;
                $display("%0t ns: result with no item pending: expected none, got trigger %0b source %0d",
                         $time, o_result.trigger, o_result.source);
            end else begin
                want = pending_results.pop_front();
                if (o_result.trigger !== want.trigger) begin
                    mismatch_count++;
                    $display("%0t ns: trigger expected %0b, got %0b",
                             $time, want.trigger, o_result.trigger);
                end
                if (o_result.source !== want.source) begin
                    mismatch_count++;
                    $display("%0t ns: source expected %0d, got %0d",
                             $time, want.source, o_result.source);
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles == STALL_LIMIT) begin
            $display("touch_swipe_gesture_detector test failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

endmodule
